@@ rtl/core/matrix3x3_inverse_macros.svh @@
// ----------------------------------------------------------------------------
// matrix3x3_inverse assertion macros
// Concurrent check wrappers; define NO_ASSERTIONS to compile them away.
// ----------------------------------------------------------------------------
`ifndef MATRIX3X3_INVERSE_MACROS_SVH
`define MATRIX3X3_INVERSE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define M3I_ASSERT(name, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("m3i check failed");
`define M3I_ASSERT_RST(name, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("m3i reset check failed");
`else
`define M3I_ASSERT(name, prop)
`define M3I_ASSERT_RST(name, prop)
`endif
`endif

@@ rtl/core/m3i_pkg.sv @@
// ----------------------------------------------------------------------------
// m3i_pkg
// Shared constants of the 3x3 matrix inverse pipeline.
// ----------------------------------------------------------------------------
package m3i_pkg;

  localparam int NLANE        = 9;  // one lane per inverse element
  localparam int NDET         = 3;  // first-row expansion terms
  localparam int FRONT_STAGES = 8;  // stages before the divider

endpackage

@@ rtl/core/matrix3x3_inverse.sv @@
// ----------------------------------------------------------------------------
// matrix3x3_inverse
// 3x3 fixed-point matrix inverse by adjugate over determinant.
// ----------------------------------------------------------------------------
// The block takes one matrix per cycle while in_stall is low and returns its
// inverse, determinant and singular/overflow flags. The divider has
// ELEM_WIDTH+2 stages, an overrange check and then one quotient bit per
// stage, and sits behind eight stages of products, cofactors and
// determinant, with one output register after it. Every stage holds its own
// valid bit, so empty stages close up while the output is stalled and new
// items keep entering until the pipeline is full.
`include "matrix3x3_inverse_macros.svh"

module matrix3x3_inverse #(
  parameter int FRAC_BITS  = 16,
  parameter int ELEM_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [ELEM_WIDTH-1:0] in_c0_r0,
  input  logic signed [ELEM_WIDTH-1:0] in_c0_r1,
  input  logic signed [ELEM_WIDTH-1:0] in_c0_r2,
  input  logic signed [ELEM_WIDTH-1:0] in_c1_r0,
  input  logic signed [ELEM_WIDTH-1:0] in_c1_r1,
  input  logic signed [ELEM_WIDTH-1:0] in_c1_r2,
  input  logic signed [ELEM_WIDTH-1:0] in_c2_r0,
  input  logic signed [ELEM_WIDTH-1:0] in_c2_r1,
  input  logic signed [ELEM_WIDTH-1:0] in_c2_r2,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [ELEM_WIDTH-1:0] inv_c0_r0,
  output logic signed [ELEM_WIDTH-1:0] inv_c0_r1,
  output logic signed [ELEM_WIDTH-1:0] inv_c0_r2,
  output logic signed [ELEM_WIDTH-1:0] inv_c1_r0,
  output logic signed [ELEM_WIDTH-1:0] inv_c1_r1,
  output logic signed [ELEM_WIDTH-1:0] inv_c1_r2,
  output logic signed [ELEM_WIDTH-1:0] inv_c2_r0,
  output logic signed [ELEM_WIDTH-1:0] inv_c2_r1,
  output logic signed [ELEM_WIDTH-1:0] inv_c2_r2,
  output logic signed [ELEM_WIDTH-1:0] det_value,
  output logic                         singular,
  output logic                         overflow
);

  localparam int W  = ELEM_WIDTH;
  localparam int F  = FRAC_BITS;
  localparam int CW = 2 * W + 1;
  localparam int DW = 3 * W + 2;
  localparam int NW = 2 * W + 2 * F;
  localparam int TW = ((NW > DW) ? NW : DW) + 2;
  localparam int DS = W + 2;
  localparam int FS = m3i_pkg::FRONT_STAGES;
  localparam int NS = FS + DS + 1;
  localparam int NL = m3i_pkg::NLANE;
  localparam int ND = m3i_pkg::NDET;

  localparam logic [DW-1:0] HALF  = DW'(1) << (2 * F - 1);
  localparam logic [DW-1:0] DLIMP = (DW'(1) << (W - 1)) - DW'(1);
  localparam logic [DW-1:0] DLIMN = DW'(1) << (W - 1);
  localparam logic [W:0]    QLIMP = ((W+1)'(1) << (W - 1)) - (W+1)'(1);
  localparam logic [W:0]    QLIMN = (W+1)'(1) << (W - 1);

  // stage valids and advance enables
  logic [NS-1:0] v;
  logic [NS-1:0] en;

  always_comb begin
    en[NS-1] = !v[NS-1] || !out_stall;
    for (int s = NS - 2; s >= 0; s--) begin
      en[s] = !v[s] || en[s+1];
    end
  end

  assign in_stall  = !en[0];
  assign out_valid = v[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) begin
        v[0] <= in_valid;
      end
      for (int s = 1; s < NS; s++) begin
        if (en[s]) begin
          v[s] <= v[s-1];
        end
      end
    end
  end

  logic signed [W-1:0] m_in [NL];

  assign m_in[0] = in_c0_r0;
  assign m_in[1] = in_c0_r1;
  assign m_in[2] = in_c0_r2;
  assign m_in[3] = in_c1_r0;
  assign m_in[4] = in_c1_r1;
  assign m_in[5] = in_c1_r2;
  assign m_in[6] = in_c2_r0;
  assign m_in[7] = in_c2_r1;
  assign m_in[8] = in_c2_r2;

  // stage 0: minor products
  logic signed [2*W-1:0] s0_pa [NL];
  logic signed [2*W-1:0] s0_pb [NL];
  logic signed [W-1:0]   s0_m0 [ND];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int c = 0; c < 3; c++) begin
        for (int r = 0; r < 3; r++) begin
          // cyclic minor of the transposed position
          s0_pa[c*3+r] <= m_in[((r+1)%3)*3 + (c+1)%3] * m_in[((r+2)%3)*3 + (c+2)%3];
          s0_pb[c*3+r] <= m_in[((r+2)%3)*3 + (c+1)%3] * m_in[((r+1)%3)*3 + (c+2)%3];
        end
      end
      for (int k = 0; k < ND; k++) begin
        s0_m0[k] <= m_in[k*3];
      end
    end
  end

  // stage 1: cofactors
  logic signed [CW-1:0] s1_cof [NL];
  logic signed [W-1:0]  s1_m0  [ND];

  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int k = 0; k < NL; k++) begin
        s1_cof[k] <= CW'(s0_pa[k]) - CW'(s0_pb[k]);
      end
      s1_m0 <= s0_m0;
    end
  end

  // stage 2: determinant partial products, cofactor split in two halves
  logic signed [2*W:0]  s2_lo  [ND];
  logic signed [2*W:0]  s2_hi  [ND];
  logic signed [CW-1:0] s2_cof [NL];

  always_ff @(posedge clk) begin
    if (en[2]) begin
      for (int k = 0; k < ND; k++) begin
        s2_lo[k] <= s1_m0[k] * $signed({1'b0, s1_cof[k][W-1:0]});
        s2_hi[k] <= s1_m0[k] * $signed(s1_cof[k][CW-1:W]);
      end
      s2_cof <= s1_cof;
    end
  end

  // stage 3: expansion terms
  logic signed [DW-1:0] s3_term [ND];
  logic signed [CW-1:0] s3_cof  [NL];

  always_ff @(posedge clk) begin
    if (en[3]) begin
      for (int k = 0; k < ND; k++) begin
        s3_term[k] <= (DW'(s2_hi[k]) <<< W) + DW'(s2_lo[k]);
      end
      s3_cof <= s2_cof;
    end
  end

  // stage 4: exact determinant
  logic signed [DW-1:0] s4_det;
  logic signed [CW-1:0] s4_cof [NL];

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s4_det <= s3_term[0] + s3_term[1] + s3_term[2];
      s4_cof <= s3_cof;
    end
  end

  // stage 5: magnitudes and signs
  logic [DW-1:0] s5_da;
  logic          s5_dneg;
  logic          s5_sing;
  logic [CW-1:0] s5_na  [NL];
  logic          s5_neg [NL];

  always_ff @(posedge clk) begin
    if (en[5]) begin
      s5_da   <= s4_det[DW-1] ? DW'(-s4_det) : DW'(s4_det);
      s5_dneg <= s4_det[DW-1];
      s5_sing <= s4_det == '0;
      for (int k = 0; k < NL; k++) begin
        s5_na[k]  <= s4_cof[k][CW-1] ? CW'(-s4_cof[k]) : CW'(s4_cof[k]);
        s5_neg[k] <= s4_cof[k][CW-1] ^ s4_det[DW-1];
      end
    end
  end

  // stage 6: rounding dividends 2n+d and divisor 2d
  logic [TW-1:0] s6_t   [NL];
  logic [TW-1:0] s6_d;
  logic [DW-1:0] s6_dm;
  logic          s6_dneg;
  logic          s6_sing;
  logic          s6_neg [NL];

  always_ff @(posedge clk) begin
    if (en[6]) begin
      for (int k = 0; k < NL; k++) begin
        s6_t[k] <= (TW'(s5_na[k]) << (2 * F + 1)) + TW'(s5_da);
      end
      s6_d    <= TW'(s5_da) << 1;
      s6_dm   <= (s5_da + HALF) >> (2 * F);
      s6_dneg <= s5_dneg;
      s6_sing <= s5_sing;
      s6_neg  <= s5_neg;
    end
  end

  // stage 7: determinant output value
  logic [TW-1:0]       s7_t   [NL];
  logic [TW-1:0]       s7_d;
  logic                s7_neg [NL];
  logic signed [W-1:0] s7_dval;
  logic                s7_dsat;
  logic                s7_sing;
  logic [DW-1:0]       dlim;
  logic [DW-1:0]       dmag;
  logic                dsat;

  always_comb begin
    dlim = s6_dneg ? DLIMN : DLIMP;
    dsat = s6_dm > dlim;
    dmag = dsat ? dlim : s6_dm;
  end

  always_ff @(posedge clk) begin
    if (en[7]) begin
      s7_t    <= s6_t;
      s7_d    <= s6_d;
      s7_neg  <= s6_neg;
      s7_dval <= s6_dneg ? W'(-dmag) : W'(dmag);
      s7_dsat <= dsat;
      s7_sing <= s6_sing;
    end
  end

  // divider and its side payload
  logic [W:0] dv_q   [NL];
  logic       dv_big [NL];
  logic       dv_neg [NL];

  m3i_div #(
    .W  (W),
    .TW (TW),
    .DS (DS)
  ) u_div (
    .clk     (clk),
    .en      (en[FS+DS-1:FS]),
    .t_in    (s7_t),
    .d_in    (s7_d),
    .neg_in  (s7_neg),
    .q_out   (dv_q),
    .big_out (dv_big),
    .neg_out (dv_neg)
  );

  logic signed [W-1:0] sd_dval [DS];
  logic                sd_dsat [DS];
  logic                sd_sing [DS];

  always_ff @(posedge clk) begin
    if (en[FS]) begin
      sd_dval[0] <= s7_dval;
      sd_dsat[0] <= s7_dsat;
      sd_sing[0] <= s7_sing;
    end
    for (int j = 1; j < DS; j++) begin
      if (en[FS+j]) begin
        sd_dval[j] <= sd_dval[j-1];
        sd_dsat[j] <= sd_dsat[j-1];
        sd_sing[j] <= sd_sing[j-1];
      end
    end
  end

  // output stage: saturate, apply sign, force zeros when singular
  logic signed [W-1:0] inv_next [NL];
  logic                ovf_next;
  logic [W:0]          qlim;
  logic [W:0]          qmag;
  logic                qsat;

  always_comb begin
    ovf_next = sd_dsat[DS-1];
    qlim     = '0;
    qmag     = '0;
    qsat     = 1'b0;
    for (int k = 0; k < NL; k++) begin
      qlim        = dv_neg[k] ? QLIMN : QLIMP;
      qsat        = dv_big[k] || (dv_q[k] > qlim);
      qmag        = qsat ? qlim : dv_q[k];
      inv_next[k] = dv_neg[k] ? W'(-qmag) : W'(qmag);
      ovf_next    = ovf_next | qsat;
    end
    if (sd_sing[DS-1]) begin
      for (int k = 0; k < NL; k++) begin
        inv_next[k] = '0;
      end
      ovf_next = 1'b0;
    end
  end

  logic signed [W-1:0] inv [NL];

  always_ff @(posedge clk) begin
    if (en[NS-1]) begin
      inv       <= inv_next;
      det_value <= sd_sing[DS-1] ? '0 : sd_dval[DS-1];
      singular  <= sd_sing[DS-1];
      overflow  <= ovf_next;
    end
  end

  assign inv_c0_r0 = inv[0];
  assign inv_c0_r1 = inv[1];
  assign inv_c0_r2 = inv[2];
  assign inv_c1_r0 = inv[3];
  assign inv_c1_r1 = inv[4];
  assign inv_c1_r2 = inv[5];
  assign inv_c2_r0 = inv[6];
  assign inv_c2_r1 = inv[7];
  assign inv_c2_r2 = inv[8];

  `M3I_ASSERT_RST(a_rst_empty, $past(rst) |-> !out_valid)
  `M3I_ASSERT(a_stall_full, in_stall |-> $countones(v) == NS)
  `M3I_ASSERT(a_sing_clean, out_valid && singular |-> !overflow && det_value == '0)
  `M3I_ASSERT(a_sing_zero, out_valid && singular |-> inv_c0_r0 == '0 && inv_c2_r2 == '0)

endmodule

@@ rtl/core/m3i_div.sv @@
// ----------------------------------------------------------------------------
// m3i_div
// Nine-lane pipelined restoring divider with a shared divisor: an overrange
// check in the first stage, then one quotient bit per stage.
// ----------------------------------------------------------------------------
module m3i_div #(
  parameter int W  = 32,
  parameter int TW = 130,
  parameter int DS = 34
) (
  input  logic          clk,
  input  logic [DS-1:0] en,
  input  logic [TW-1:0] t_in   [m3i_pkg::NLANE],
  input  logic [TW-1:0] d_in,
  input  logic          neg_in [m3i_pkg::NLANE],
  output logic [W:0]    q_out  [m3i_pkg::NLANE],
  output logic          big_out[m3i_pkg::NLANE],
  output logic          neg_out[m3i_pkg::NLANE]
);

  localparam int XW = TW + W + 2;

  logic [TW-1:0] r_t  [DS][m3i_pkg::NLANE];
  logic [W:0]    r_q  [DS][m3i_pkg::NLANE];
  logic          r_big[DS][m3i_pkg::NLANE];
  logic          r_neg[DS][m3i_pkg::NLANE];
  logic [TW-1:0] r_d  [DS];

  // first stage: quotient would need more than W+1 bits
  always_ff @(posedge clk) begin
    if (en[0]) begin
      r_d[0] <= d_in;
      for (int l = 0; l < m3i_pkg::NLANE; l++) begin
        r_t[0][l]   <= t_in[l];
        r_q[0][l]   <= '0;
        r_neg[0][l] <= neg_in[l];
        r_big[0][l] <= XW'(t_in[l]) >= (XW'(d_in) << (W + 1));
      end
    end
  end

  for (genvar j = 1; j < DS; j++) begin : g_step
    localparam int SH = W + 1 - j;
    logic [XW-1:0] dsh;
    logic          ge [m3i_pkg::NLANE];

    assign dsh = XW'(r_d[j-1]) << SH;

    always_comb begin
      for (int l = 0; l < m3i_pkg::NLANE; l++) begin
        ge[l] = XW'(r_t[j-1][l]) >= dsh;
      end
    end

    always_ff @(posedge clk) begin
      if (en[j]) begin
        r_d[j] <= r_d[j-1];
        for (int l = 0; l < m3i_pkg::NLANE; l++) begin
          r_t[j][l]   <= ge[l] ? TW'(XW'(r_t[j-1][l]) - dsh) : r_t[j-1][l];
          r_q[j][l]   <= r_q[j-1][l] | (ge[l] ? ((W+1)'(1) << SH) : '0);
          r_big[j][l] <= r_big[j-1][l];
          r_neg[j][l] <= r_neg[j-1][l];
        end
      end
    end
  end

  always_comb begin
    for (int l = 0; l < m3i_pkg::NLANE; l++) begin
      q_out[l]   = r_q[DS-1][l];
      big_out[l] = r_big[DS-1][l];
      neg_out[l] = r_neg[DS-1][l];
    end
  end

endmodule

@@ dv/matrix3x3_inverse_tb.sv @@
// ----------------------------------------------------------------------------
// matrix3x3_inverse_tb
// Drives matrices through the inverse pipeline and checks each result against
// an exact wide-integer model of adjugate over determinant, or against the stored result of a typed table row.
// A directed table comes first, then random matrices under several
// idle/stall mixes, including a long output hold that fills the pipeline.
// ----------------------------------------------------------------------------
module matrix3x3_inverse_tb;

  localparam int W          = 32;
  localparam int FB         = 16;
  localparam int N_RANDOM   = 2000;
  localparam int DRAIN_WAIT = 80;
  localparam int IDLE_LIMIT = 3000;

  typedef logic signed [255:0] wide_t;
  typedef logic [m3i_pkg::NLANE-1:0][W-1:0] matrix_t;

  typedef struct packed {
    matrix_t        inv;
    logic [W-1:0]   det;
    logic           singular;
    logic           overflow;
  } inv_result_t;

  typedef struct packed {
    matrix_t     m;
    logic        typed;
    inv_result_t res;
  } vector_row_t;

  logic clk, rst;
  logic in_valid, in_stall, out_valid, out_stall;
  matrix_t in_m;
  logic [m3i_pkg::NLANE-1:0][W-1:0] inv_o;
  logic [W-1:0] det_o;
  logic sing_o, ovf_o;

  inv_result_t expected_q[$];
  int err_count = 0;
  int idle_cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit pressure_req = 0;

  matrix3x3_inverse u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_c0_r0(in_m[0]), .in_c0_r1(in_m[1]), .in_c0_r2(in_m[2]),
    .in_c1_r0(in_m[3]), .in_c1_r1(in_m[4]), .in_c1_r2(in_m[5]),
    .in_c2_r0(in_m[6]), .in_c2_r1(in_m[7]), .in_c2_r2(in_m[8]),
    .out_valid(out_valid), .out_stall(out_stall),
    .inv_c0_r0(inv_o[0]), .inv_c0_r1(inv_o[1]), .inv_c0_r2(inv_o[2]),
    .inv_c1_r0(inv_o[3]), .inv_c1_r1(inv_o[4]), .inv_c1_r2(inv_o[5]),
    .inv_c2_r0(inv_o[6]), .inv_c2_r1(inv_o[7]), .inv_c2_r2(inv_o[8]),
    .det_value(det_o), .singular(sing_o), .overflow(ovf_o)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // quotient rounded half away from zero, clamped to the element range
  function automatic logic [W-1:0] round_quot(input wide_t num, input wide_t den,
                                              inout logic sat);
    logic neg;
    logic [255:0] n, d, q, lim;
    neg = num[255] ^ den[255];
    n = num[255] ? -num : num;
    d = den[255] ? -den : den;
    q = (2 * n + d) / (2 * d);
    lim = neg ? (256'd1 << (W - 1)) : ((256'd1 << (W - 1)) - 1);
    if (q > lim) begin
      q = lim;
      sat = 1'b1;
    end
    return neg ? -q[W-1:0] : q[W-1:0];
  endfunction

  function automatic inv_result_t invert_matrix(input matrix_t a);
    wide_t e[m3i_pkg::NLANE];
    wide_t cof[m3i_pkg::NLANE];
    wide_t det;
    inv_result_t r;
    logic sat;
    int c1, c2, r1, r2;
    for (int k = 0; k < m3i_pkg::NLANE; k++) e[k] = wide_t'($signed(a[k]));
    // transposed cofactors taken as cyclic minors
    for (int c = 0; c < 3; c++) begin
      for (int rw = 0; rw < 3; rw++) begin
        c1 = (rw + 1) % 3; c2 = (rw + 2) % 3;
        r1 = (c + 1) % 3;  r2 = (c + 2) % 3;
        cof[c*3+rw] = e[c1*3+r1] * e[c2*3+r2] - e[c2*3+r1] * e[c1*3+r2];
      end
    end
    det = 0;
    for (int k = 0; k < m3i_pkg::NDET; k++) det = det + e[k*3] * cof[k];
    r = '0;
    sat = 1'b0;
    if (det == 0) begin
      r.singular = 1'b1;
      return r;
    end
    for (int k = 0; k < m3i_pkg::NLANE; k++)
      r.inv[k] = round_quot(cof[k] <<< (2 * FB), det, sat);
    r.det = round_quot(det, wide_t'(1) <<< (2 * FB), sat);
    r.overflow = sat;
    return r;
  endfunction

  function automatic logic [W-1:0] pick_elem();
    case ($urandom_range(0, 5))
      0, 1: return $urandom();
      2: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
      default: return $signed($urandom_range(0, 1 << 20)) - (1 << 19);
    endcase
  endfunction

  function automatic matrix_t random_matrix();
    matrix_t m;
    int src, dst;
    for (int k = 0; k < m3i_pkg::NLANE; k++) m[k] = pick_elem();
    case ($urandom_range(0, 9))
      0: begin  // duplicate a column so the determinant vanishes
        src = $urandom_range(0, 2);
        dst = (src + $urandom_range(1, 2)) % 3;
        for (int rw = 0; rw < 3; rw++) m[dst*3+rw] = m[src*3+rw];
      end
      1: begin  // near identity
        for (int k = 0; k < m3i_pkg::NLANE; k++)
          m[k] = ((k % 4 == 0) ? 32'h0001_0000 : 32'h0) + $urandom_range(0, 255);
      end
      2: for (int k = 0; k < m3i_pkg::NLANE; k++) m[k] = $urandom();
      default: ;
    endcase
    return m;
  endfunction

  function automatic matrix_t diag3(input logic [W-1:0] v);
    matrix_t m;
    m = '0;
    m[0] = v; m[4] = v; m[8] = v;
    return m;
  endfunction

  vector_row_t dir_table[$];
  inv_result_t ident_res, sing_res;

  task automatic build_table();
    matrix_t m;
    vector_row_t row;
    ident_res = '0;
    ident_res.inv[0] = 32'h0001_0000;
    ident_res.inv[4] = 32'h0001_0000;
    ident_res.inv[8] = 32'h0001_0000;
    ident_res.det = 32'h0001_0000;
    sing_res = '0;
    sing_res.singular = 1'b1;
    dir_table.push_back('{diag3(32'h0001_0000), 1'b1, ident_res});
    dir_table.push_back('{matrix_t'('0), 1'b1, sing_res});
    dir_table.push_back('{{m3i_pkg::NLANE{32'h8000_0000}}, 1'b1, sing_res});
    dir_table.push_back('{{m3i_pkg::NLANE{32'h7fff_ffff}}, 1'b1, sing_res});
    dir_table.push_back('{{m3i_pkg::NLANE{32'hffff_ffff}}, 1'b1, sing_res});
    dir_table.push_back('{diag3(32'hffff_0000), 1'b0, '0});
    dir_table.push_back('{diag3(32'h0002_0000), 1'b0, '0});
    dir_table.push_back('{diag3(32'h8000_0000), 1'b0, '0});
    dir_table.push_back('{diag3(32'h7fff_ffff), 1'b0, '0});
    // tiny nonzero determinant: rounds to zero but is not singular
    dir_table.push_back('{diag3(32'h0000_0001), 1'b0, '0});
    dir_table.push_back('{diag3(32'h0000_0100), 1'b0, '0});
    m = diag3(32'h0001_0000);
    m[3] = 32'h8000_0000; m[6] = 32'h7fff_ffff; m[7] = 32'h0000_0001;
    dir_table.push_back('{m, 1'b0, '0});
    m = '0;
    m[1] = 32'h0001_0000; m[3] = 32'h0001_0000; m[8] = 32'hffff_0000;
    dir_table.push_back('{m, 1'b0, '0});
    m = '0;
    m[2] = 32'h0003_0000; m[4] = 32'hfffe_0000; m[6] = 32'h0000_8000;
    dir_table.push_back('{m, 1'b0, '0});
    for (int k = 0; k < 4; k++) begin
      for (int j = 0; j < m3i_pkg::NLANE; j++) m[j] = $urandom();
      dir_table.push_back('{m, 1'b0, '0});
    end
  endtask

  task automatic report_mismatch(input string what, input logic [W-1:0] got,
                                 input logic [W-1:0] want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    err_count++;
  endtask

  // sender
  vector_row_t pending;
  int sent;
  int total;

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_m = '0;
    build_table();
    total = dir_table.size() + N_RANDOM;
    sent = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    while (sent < total) begin
      @(posedge clk);
      if (in_valid && !in_stall) begin
        expected_q.push_back(pending.typed ? pending.res : invert_matrix(pending.m));
        sent++;
      end
      if (!in_valid || !in_stall) begin
        if (sent - dir_table.size() == N_RANDOM / 4) begin
          send_idle_pct = 86;
          recv_stall_pct = 0;
        end else if (sent - dir_table.size() == N_RANDOM / 2) begin
          send_idle_pct = 0;
          recv_stall_pct = 86;
        end else if (sent - dir_table.size() == 3 * N_RANDOM / 4) begin
          send_idle_pct = 8;
          recv_stall_pct = 8;
        end else if (sent == dir_table.size() + 100) begin
          pressure_req = 1'b1;
        end
        if (sent + (in_valid ? 0 : 0) < total &&
            !(in_valid && !in_stall && sent == total) &&
            $urandom_range(0, 99) >= send_idle_pct) begin
          if (sent < dir_table.size()) pending = dir_table[sent];
          else pending = '{random_matrix(), 1'b0, '0};
          in_m <= pending.m;
          in_valid <= (sent < total);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (err_count == 0) $display("matrix3x3_inverse_tb: done, clean");
    else $display("matrix3x3_inverse_tb: done, errors");
    $finish;
  end

  // receiver: random stalls, plus one long hold to back up the pipeline
  inv_result_t want;
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall && !rst) begin
        if (expected_q.size() == 0) begin
          report_mismatch("result item with no expectation", '0, '0);
        end else begin
          want = expected_q.pop_front();
          for (int k = 0; k < m3i_pkg::NLANE; k++)
            if (inv_o[k] !== want.inv[k])
              report_mismatch($sformatf("inv[%0d]", k), inv_o[k], want.inv[k]);
          if (det_o !== want.det) report_mismatch("det_value", det_o, want.det);
          if (sing_o !== want.singular)
            report_mismatch("singular", W'(sing_o), W'(want.singular));
          if (ovf_o !== want.overflow)
            report_mismatch("overflow", W'(ovf_o), W'(want.overflow));
        end
      end
      if (pressure_req) begin
        pressure_req = 1'b0;
        out_stall <= 1'b1;
        repeat (200) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("matrix3x3_inverse_tb: done, errors");
      $finish;
    end
  end

endmodule
